[src/fcwd_pkg.sv]
// ----------------------------------------------------------------------------
// fcwd_pkg
// shared constants, codes and types of the front coded word decoder
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fcwd_pkg;

    localparam int MAX_WORD_DEF     = 32;
    localparam int SUFFIX_LEN_DEF   = 16;
    localparam int SUFFIX_COUNT_DEF = 128;
    localparam int RESULT_LIMIT     = 32;

    localparam logic [7:0] LETTER_A = 8'd65;
    localparam logic [7:0] HIGH_BIT = 8'd128;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    localparam logic [6:0] NO_SUFFIX_RESET = 7'd127;

    localparam logic OP_STREAM    = 1'b0;
    localparam logic OP_SUFFIX_WR = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_EBCDIC_MODE    = 2'd0,
        CFG_NO_SUFFIX_CODE = 2'd1
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PFX_RD,
        ST_PFX_OUT,
        ST_PLAIN,
        ST_SFX_RD,
        ST_SFX_CHK,
        ST_END
    } state_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       has_char;
        logic       word_end;
        logic       overflowed;
    } result_t;

endpackage

[src/fcwd_ram.sv]
// ----------------------------------------------------------------------------
// fcwd_ram
// generic simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fcwd_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 32,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[src/fcwd_out_reg.sv]
// ----------------------------------------------------------------------------
// fcwd_out_reg
// result output register, holds one transaction until it is taken
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fcwd_out_reg (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              load,
    input  fcwd_pkg::result_t load_data,
    output logic              out_free,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [7:0]        m_ch,
    output logic              m_has_char,
    output logic              m_word_end,
    output logic              m_overflowed
);
    import fcwd_pkg::*;

    logic    valid_reg;
    result_t data_reg;

    assign out_free = !valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= load_data;
        end
    end

    assign m_valid      = valid_reg;
    assign m_ch         = data_reg.ch;
    assign m_has_char   = data_reg.has_char;
    assign m_word_end   = data_reg.word_end;
    assign m_overflowed = data_reg.overflowed;

endmodule

[src/fcwd_seq.sv]
// ----------------------------------------------------------------------------
// fcwd_seq
// sequencer: one shared index counter walks the clearing pass, the prefix
// copy and the suffix expansion, at most one access to each ram per step
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fcwd_seq #(
    parameter  int MAX_WORD     = fcwd_pkg::MAX_WORD_DEF,
    parameter  int SUFFIX_LEN   = fcwd_pkg::SUFFIX_LEN_DEF,
    parameter  int SUFFIX_COUNT = fcwd_pkg::SUFFIX_COUNT_DEF,
    localparam int TAB_DEPTH    = SUFFIX_COUNT * SUFFIX_LEN,
    localparam int WAW          = $clog2(MAX_WORD),
    localparam int TAW          = (TAB_DEPTH > 1) ? $clog2(TAB_DEPTH) : 1
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic                             s_opcode,
    input  logic [7:0]                       s_data_byte,
    input  logic [6:0]                       s_suffix_slot,
    input  logic [3:0]                       s_char_position,
    input  logic                             cfg_we,
    input  logic [fcwd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [fcwd_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             out_free,
    output logic                             res_load,
    output fcwd_pkg::result_t                res_data,
    output logic                             word_we,
    output logic [WAW-1:0]                   word_waddr,
    output logic [7:0]                       word_wdata,
    output logic                             word_re,
    output logic [WAW-1:0]                   word_raddr,
    input  logic [7:0]                       word_rdata,
    output logic                             sfx_we,
    output logic [TAW-1:0]                   sfx_waddr,
    output logic [7:0]                       sfx_wdata,
    output logic                             sfx_re,
    output logic [TAW-1:0]                   sfx_raddr,
    input  logic [7:0]                       sfx_rdata
);
    import fcwd_pkg::*;

    localparam int CLR_DEPTH = (TAB_DEPTH > MAX_WORD) ? TAB_DEPTH : MAX_WORD;
    localparam int CNT_W     = $clog2(CLR_DEPTH);
    localparam int NXT_W     = CNT_W + 1;
    localparam int WP_W      = $clog2(MAX_WORD + 1);
    localparam int LIMIT     = (MAX_WORD < RESULT_LIMIT) ? MAX_WORD : RESULT_LIMIT;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [WP_W-1:0]  wp_reg, wp_next;
    logic             expect_reg, expect_next;
    logic             ovf_reg, ovf_next;
    logic [7:0]       byte_reg, byte_next;
    logic [TAW-1:0]   base_reg, base_next;
    logic             pend_valid_reg, pend_valid_next;
    logic [7:0]       pend_ch_reg, pend_ch_next;
    logic             ebcdic_reg;
    logic [6:0]       nsc_reg;

    logic [7:0]       same_raw;
    logic             same_ovf;
    logic [WP_W-1:0]  same_cnt;
    logic             is_plain;
    logic [6:0]       code_in;
    logic             sfx_hit;
    logic             sfx_wr_ok;
    logic             wp_full;
    logic [NXT_W-1:0] idx_inc;
    logic             accept;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ebcdic_reg <= 1'b0;
            nsc_reg    <= NO_SUFFIX_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_EBCDIC_MODE:    ebcdic_reg <= cfg_data[0];
                CFG_NO_SUFFIX_CODE: nsc_reg    <= cfg_data[6:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            idx_reg        <= '0;
            wp_reg         <= '0;
            expect_reg     <= 1'b1;
            ovf_reg        <= 1'b0;
            pend_valid_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            wp_reg         <= wp_next;
            expect_reg     <= expect_next;
            ovf_reg        <= ovf_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg    <= byte_next;
        base_reg    <= base_next;
        pend_ch_reg <= pend_ch_next;
    end

    assign same_raw  = (s_data_byte >= LETTER_A) ? s_data_byte - LETTER_A : 8'd0;
    assign same_ovf  = same_raw > 8'(LIMIT);
    assign same_cnt  = same_ovf ? WP_W'(LIMIT) : WP_W'(same_raw);
    assign is_plain  = ebcdic_reg ? (s_data_byte > HIGH_BIT) : (s_data_byte < HIGH_BIT);
    assign code_in   = s_data_byte[6:0];
    assign sfx_hit   = (code_in != nsc_reg) && ({1'b0, code_in} < 8'(SUFFIX_COUNT));
    assign sfx_wr_ok = ({1'b0, s_suffix_slot} < 8'(SUFFIX_COUNT))
                    && ({2'b00, s_char_position} < 6'(SUFFIX_LEN));
    assign wp_full   = wp_reg >= WP_W'(MAX_WORD);
    assign idx_inc   = NXT_W'(idx_reg) + 1'b1;

    assign s_ready    = (state_reg == ST_IDLE);
    assign accept     = s_valid && s_ready;
    assign word_raddr = idx_reg[WAW-1:0];
    assign sfx_raddr  = base_reg + idx_reg[TAW-1:0];

    always_comb begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        wp_next         = wp_reg;
        expect_next     = expect_reg;
        ovf_next        = ovf_reg;
        byte_next       = byte_reg;
        base_next       = base_reg;
        pend_valid_next = pend_valid_reg;
        pend_ch_next    = pend_ch_reg;
        res_load        = 1'b0;
        res_data        = '0;
        word_we         = 1'b0;
        word_waddr      = wp_reg[WAW-1:0];
        word_wdata      = 8'd0;
        word_re         = 1'b0;
        sfx_we          = 1'b0;
        sfx_waddr       = TAW'(int'(s_suffix_slot) * SUFFIX_LEN + int'(s_char_position));
        sfx_wdata       = s_data_byte;
        sfx_re          = 1'b0;

        unique case (state_reg)
            ST_CLEAR: begin
                word_we    = NXT_W'(idx_reg) < NXT_W'(MAX_WORD);
                word_waddr = idx_reg[WAW-1:0];
                sfx_we     = NXT_W'(idx_reg) < NXT_W'(TAB_DEPTH);
                sfx_waddr  = idx_reg[TAW-1:0];
                sfx_wdata  = 8'd0;
                idx_next   = idx_inc[CNT_W-1:0];
                if (idx_inc == NXT_W'(CLR_DEPTH)) begin
                    idx_next   = '0;
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE: begin
                if (accept) begin
                    if (s_opcode == OP_SUFFIX_WR) begin
                        sfx_we = sfx_wr_ok;
                    end else if (expect_reg) begin
                        ovf_next    = same_ovf;
                        wp_next     = same_cnt;
                        expect_next = 1'b0;
                        idx_next    = '0;
                        if (same_cnt != '0) begin
                            state_next = ST_PFX_RD;
                        end
                    end else if (is_plain) begin
                        byte_next  = s_data_byte;
                        state_next = ST_PLAIN;
                    end else begin
                        base_next       = TAW'(int'(code_in) * SUFFIX_LEN);
                        idx_next        = '0;
                        pend_valid_next = 1'b0;
                        state_next      = sfx_hit ? ST_SFX_RD : ST_END;
                    end
                end
            end

            ST_PFX_RD: begin
                word_re    = 1'b1;
                state_next = ST_PFX_OUT;
            end

            ST_PFX_OUT: begin
                if (out_free) begin
                    res_load          = 1'b1;
                    res_data.ch       = word_rdata;
                    res_data.has_char = 1'b1;
                    idx_next          = idx_inc[CNT_W-1:0];
                    state_next        = (idx_inc == NXT_W'(wp_reg)) ? ST_IDLE : ST_PFX_RD;
                end
            end

            ST_PLAIN: begin
                if (wp_full) begin
                    ovf_next   = 1'b1;
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    word_we           = 1'b1;
                    word_wdata        = byte_reg;
                    wp_next           = wp_reg + 1'b1;
                    res_load          = 1'b1;
                    res_data.ch       = byte_reg;
                    res_data.has_char = 1'b1;
                    state_next        = ST_IDLE;
                end
            end

            ST_SFX_RD: begin
                sfx_re     = 1'b1;
                state_next = ST_SFX_CHK;
            end

            ST_SFX_CHK: begin
                if (sfx_rdata == 8'd0) begin
                    state_next = ST_END;
                end else if (!wp_full && pend_valid_reg && !out_free) begin
                    state_next = ST_SFX_CHK;
                end else begin
                    if (wp_full) begin
                        ovf_next = 1'b1;
                    end else begin
                        // previous suffix character goes out, this one is held
                        res_load          = pend_valid_reg;
                        res_data.ch       = pend_ch_reg;
                        res_data.has_char = 1'b1;
                        pend_ch_next      = sfx_rdata;
                        pend_valid_next   = 1'b1;
                        word_we           = 1'b1;
                        word_wdata        = sfx_rdata;
                        wp_next           = wp_reg + 1'b1;
                    end
                    idx_next   = idx_inc[CNT_W-1:0];
                    state_next = (idx_reg == CNT_W'(SUFFIX_LEN - 1)) ? ST_END : ST_SFX_RD;
                end
            end

            ST_END: begin
                if (out_free) begin
                    res_load            = 1'b1;
                    res_data.ch         = pend_valid_reg ? pend_ch_reg : 8'd0;
                    res_data.has_char   = pend_valid_reg;
                    res_data.word_end   = 1'b1;
                    res_data.overflowed = ovf_reg;
                    word_we             = !wp_full;
                    word_wdata          = 8'd0;
                    wp_next             = '0;
                    expect_next         = 1'b1;
                    ovf_next            = 1'b0;
                    pend_valid_next     = 1'b0;
                    idx_next            = '0;
                    state_next          = ST_IDLE;
                end
            end

            default: state_next = ST_CLEAR;
        endcase
    end

endmodule

[src/front_coded_word_decoder_unit.sv]
// ----------------------------------------------------------------------------
// front_coded_word_decoder_unit
// opcode 1 transaction: a suffix table write; plain byte: one result, or none when
// the word store is full; count byte: each prefix character is read from the word
// store, then sent; terminator: each suffix table character is read, then checked,
// then a word end result goes out; one transaction at a time; results leave through
// a one-deep output register; after reset a clearing pass zeroes both stores
// over max(SUFFIX_COUNT*SUFFIX_LEN, MAX_WORD) addresses, s_ready stays low meanwhile
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module front_coded_word_decoder_unit #(
    parameter int MAX_WORD     = fcwd_pkg::MAX_WORD_DEF,
    parameter int SUFFIX_LEN   = fcwd_pkg::SUFFIX_LEN_DEF,
    parameter int SUFFIX_COUNT = fcwd_pkg::SUFFIX_COUNT_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_opcode,
    input  logic [7:0]                      s_data_byte,
    input  logic [6:0]                      s_suffix_slot,
    input  logic [3:0]                      s_char_position,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [7:0]                      m_ch,
    output logic                            m_has_char,
    output logic                            m_word_end,
    output logic                            m_overflowed,
    input  logic                            cfg_we,
    input  logic [fcwd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fcwd_pkg::CFG_DATA_W-1:0] cfg_data
);
    import fcwd_pkg::*;

    localparam int TAB_DEPTH = SUFFIX_COUNT * SUFFIX_LEN;
    localparam int WAW       = $clog2(MAX_WORD);
    localparam int TAW       = (TAB_DEPTH > 1) ? $clog2(TAB_DEPTH) : 1;

    logic           out_free;
    logic           res_load;
    result_t        res_data;
    logic           word_we, word_re;
    logic [WAW-1:0] word_waddr, word_raddr;
    logic [7:0]     word_wdata, word_rdata;
    logic           sfx_we, sfx_re;
    logic [TAW-1:0] sfx_waddr, sfx_raddr;
    logic [7:0]     sfx_wdata, sfx_rdata;

    fcwd_seq #(
        .MAX_WORD     (MAX_WORD),
        .SUFFIX_LEN   (SUFFIX_LEN),
        .SUFFIX_COUNT (SUFFIX_COUNT)
    ) u_seq (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_opcode        (s_opcode),
        .s_data_byte     (s_data_byte),
        .s_suffix_slot   (s_suffix_slot),
        .s_char_position (s_char_position),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .out_free        (out_free),
        .res_load        (res_load),
        .res_data        (res_data),
        .word_we         (word_we),
        .word_waddr      (word_waddr),
        .word_wdata      (word_wdata),
        .word_re         (word_re),
        .word_raddr      (word_raddr),
        .word_rdata      (word_rdata),
        .sfx_we          (sfx_we),
        .sfx_waddr       (sfx_waddr),
        .sfx_wdata       (sfx_wdata),
        .sfx_re          (sfx_re),
        .sfx_raddr       (sfx_raddr),
        .sfx_rdata       (sfx_rdata)
    );

    fcwd_ram #(
        .WIDTH (8),
        .DEPTH (MAX_WORD)
    ) u_word_store (
        .aclk  (aclk),
        .we    (word_we),
        .waddr (word_waddr),
        .wdata (word_wdata),
        .re    (word_re),
        .raddr (word_raddr),
        .rdata (word_rdata)
    );

    fcwd_ram #(
        .WIDTH (8),
        .DEPTH (TAB_DEPTH)
    ) u_suffix_table (
        .aclk  (aclk),
        .we    (sfx_we),
        .waddr (sfx_waddr),
        .wdata (sfx_wdata),
        .re    (sfx_re),
        .raddr (sfx_raddr),
        .rdata (sfx_rdata)
    );

    fcwd_out_reg u_out (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .load         (res_load),
        .load_data    (res_data),
        .out_free     (out_free),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_ch         (m_ch),
        .m_has_char   (m_has_char),
        .m_word_end   (m_word_end),
        .m_overflowed (m_overflowed)
    );

endmodule

[src/fcwd_checker.sv]
// ----------------------------------------------------------------------------
// fcwd_checker
// port level checks on the front coded word decoder
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fcwd_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_ch,
    input logic       m_has_char,
    input logic       m_word_end,
    input logic       m_overflowed
);

    // reset empties the output and starts the clearing pass
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && !s_ready)
        else $error("output valid or input ready right after reset");

    // a bare end marker only closes a word
    a_bare_marker: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_has_char |-> m_word_end && (m_ch == 8'd0))
        else $error("bare marker without word end");

    // overflow is reported on the word end transaction only
    a_ovf_at_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_overflowed |-> m_word_end)
        else $error("overflow flag outside word end");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_ch) && $stable(m_has_char)
            && $stable(m_word_end) && $stable(m_overflowed))
        else $error("stalled result changed");

endmodule

bind front_coded_word_decoder_unit fcwd_checker u_fcwd_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_ch         (m_ch),
    .m_has_char   (m_has_char),
    .m_word_end   (m_word_end),
    .m_overflowed (m_overflowed)
);

[dv/word_decode_checker.sv]
// ----------------------------------------------------------------------------
// word_decode_checker
// watches the byte and character channels of the front coded word decoder,
// tracks the register writes, works out the characters each accepted byte
// should produce and compares every character transaction with the oldest
// one still owed
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module word_decode_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    input  logic                            s_ready,
    input  logic                            s_opcode,
    input  logic [7:0]                      s_data_byte,
    input  logic [6:0]                      s_suffix_slot,
    input  logic [3:0]                      s_char_position,
    input  logic                            m_valid,
    input  logic                            m_ready,
    input  logic [7:0]                      m_ch,
    input  logic                            m_has_char,
    input  logic                            m_word_end,
    input  logic                            m_overflowed,
    input  logic                            cfg_we,
    input  logic [fcwd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fcwd_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                              errors,
    output int                              pending
);
    import fcwd_pkg::*;

    logic [7:0] prev_word [MAX_WORD_DEF];
    int         fill;
    logic       at_count;
    logic       clipped;
    logic [7:0] suffix_chars [SUFFIX_COUNT_DEF][SUFFIX_LEN_DEF];
    logic       ebcdic;
    logic [6:0] bare_code;
    result_t    owed_chars [$];

    initial begin
        errors  = 0;
        pending = 0;
    end

    function automatic result_t plain_result(logic [7:0] c);
        result_t r;
        r.ch         = c;
        r.has_char   = 1'b1;
        r.word_end   = 1'b0;
        r.overflowed = 1'b0;
        return r;
    endfunction

    function automatic bit keep_char(logic [7:0] c);
        if (fill < MAX_WORD_DEF) begin
            prev_word[fill] = c;
            fill++;
            return 1'b1;
        end
        clipped = 1'b1;
        return 1'b0;
    endfunction

    function automatic void decode_byte(logic op, logic [7:0] b, logic [6:0] slot,
                                        logic [3:0] pos);
        int         shared;
        int         n;
        logic [6:0] code;
        logic [7:0] c;
        result_t    word_tail [SUFFIX_LEN_DEF];
        if (op == OP_SUFFIX_WR) begin
            if (int'(slot) < SUFFIX_COUNT_DEF && int'(pos) < SUFFIX_LEN_DEF) begin
                suffix_chars[slot][pos] = b;
            end
            return;
        end
        if (at_count) begin
            shared  = (b >= LETTER_A) ? int'(b - LETTER_A) : 0;
            clipped = 1'b0;
            if (shared > MAX_WORD_DEF) begin
                shared  = MAX_WORD_DEF;
                clipped = 1'b1;
            end
            if (shared > RESULT_LIMIT) begin
                shared  = RESULT_LIMIT;
                clipped = 1'b1;
            end
            for (int i = 0; i < shared; i++) begin
                owed_chars.push_back(plain_result(prev_word[i]));
            end
            fill     = shared;
            at_count = 1'b0;
            return;
        end
        if (ebcdic ? (b > HIGH_BIT) : (b < HIGH_BIT)) begin
            if (keep_char(b)) begin
                owed_chars.push_back(plain_result(b));
            end
            return;
        end
        // terminator: append the chosen suffix, then close the word
        code = b[6:0];
        n    = 0;
        if (code != bare_code && int'(code) < SUFFIX_COUNT_DEF) begin
            for (int i = 0; i < SUFFIX_LEN_DEF; i++) begin
                c = suffix_chars[code][i];
                if (c == 8'd0) break;
                if (keep_char(c)) begin
                    word_tail[n] = plain_result(c);
                    n++;
                end
            end
        end
        if (n == 0) begin
            word_tail[0] = plain_result(8'd0);
            word_tail[0].has_char = 1'b0;
            n = 1;
        end
        word_tail[n-1].word_end   = 1'b1;
        word_tail[n-1].overflowed = clipped;
        for (int i = 0; i < n; i++) begin
            owed_chars.push_back(word_tail[i]);
        end
        if (fill < MAX_WORD_DEF) begin
            prev_word[fill] = 8'd0;
        end
        fill     = 0;
        at_count = 1'b1;
        clipped  = 1'b0;
    endfunction

    task automatic check_field(string name, logic [7:0] want, logic [7:0] seen);
        if (seen !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, seen);
        end
    endtask

    always @(posedge aclk) begin
        result_t want;
        if (!aresetn) begin
            foreach (prev_word[i]) prev_word[i] = 8'd0;
            foreach (suffix_chars[i, j]) suffix_chars[i][j] = 8'd0;
            fill      = 0;
            at_count  = 1'b1;
            clipped   = 1'b0;
            ebcdic    = 1'b0;
            bare_code = NO_SUFFIX_RESET;
            owed_chars.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (owed_chars.size() == 0) begin
                    errors++;
                    $display("%0t: character transaction with nothing owed, ch %0h has_char %0b",
                             $time, m_ch, m_has_char);
                    $display("    word_end %0b overflowed %0b", m_word_end, m_overflowed);
                end else begin
                    want = owed_chars.pop_front();
                    check_field("ch", want.ch, m_ch);
                    check_field("has_char", 8'(want.has_char), 8'(m_has_char));
                    check_field("word_end", 8'(want.word_end), 8'(m_word_end));
                    check_field("overflowed", 8'(want.overflowed), 8'(m_overflowed));
                end
            end
            if (cfg_we) begin
                case (cfg_index)
                    CFG_EBCDIC_MODE: begin
                        ebcdic = cfg_data[0];
                    end
                    CFG_NO_SUFFIX_CODE: begin
                        bare_code = cfg_data[6:0];
                    end
                    default: begin
                    end
                endcase
            end
            if (s_valid && s_ready) begin
                decode_byte(s_opcode, s_data_byte, s_suffix_slot, s_char_position);
            end
        end
        pending <= owed_chars.size();
    end

endmodule

[dv/tb_front_coded_word_decoder_unit.sv]
// ----------------------------------------------------------------------------
// tb_front_coded_word_decoder_unit
// drives front coded byte streams and suffix table loads into the decoder
// under several register settings, with bursty input and a stalling output;
// a separate checker predicts and compares every character transaction
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_front_coded_word_decoder_unit;
    import fcwd_pkg::*;

    localparam int STUCK_LIMIT     = 10000;
    localparam int SETTLE_CYCLES   = 100;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int PHASE_ITEMS     = 45;
    localparam int PHASES          = 5;

    // an index with no register behind it
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd2;

    typedef enum int {RX_OPEN, RX_COIN, RX_BEAT, RX_SPARSE} rx_mode_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    logic                  s_opcode;
    logic [7:0]            s_data_byte;
    logic [6:0]            s_suffix_slot;
    logic [3:0]            s_char_position;
    logic                  m_valid;
    logic                  m_ready;
    logic [7:0]            m_ch;
    logic                  m_has_char;
    logic                  m_word_end;
    logic                  m_overflowed;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int         mismatch_count;
    int         chars_owed;
    int         burst_left = 0;
    int         sent = 0;
    int         stuck_cycles;
    bit         tx_gappy;
    bit         hold_off_req = 1'b0;
    bit         ebcdic;
    logic [6:0] no_sfx;
    logic [6:0] sfx_slot [4];

    front_coded_word_decoder_unit uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_opcode        (s_opcode),
        .s_data_byte     (s_data_byte),
        .s_suffix_slot   (s_suffix_slot),
        .s_char_position (s_char_position),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_ch            (m_ch),
        .m_has_char      (m_has_char),
        .m_word_end      (m_word_end),
        .m_overflowed    (m_overflowed),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    word_decode_checker chk (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_opcode        (s_opcode),
        .s_data_byte     (s_data_byte),
        .s_suffix_slot   (s_suffix_slot),
        .s_char_position (s_char_position),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_ch            (m_ch),
        .m_has_char      (m_has_char),
        .m_word_end      (m_word_end),
        .m_overflowed    (m_overflowed),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .errors          (mismatch_count),
        .pending         (chars_owed)
    );

    initial aclk = 1'b0;

    always #5 aclk = ~aclk;

    task automatic send_byte(input logic op, input logic [7:0] b, input logic [6:0] slot,
                             input logic [3:0] pos);
        int gap;
        if (burst_left == 0) begin
            gap        = tx_gappy ? $urandom_range(1, 8) : 0;
            burst_left = $urandom_range(1, 16);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid         <= 1'b1;
        s_opcode        <= op;
        s_data_byte     <= b;
        s_suffix_slot   <= slot;
        s_char_position <= pos;
        do @(posedge aclk); while (!s_ready);
        sent++;
    endtask

    task automatic stream_byte(input logic [7:0] b);
        send_byte(OP_STREAM, b, 7'($urandom_range(0, 127)), 4'($urandom_range(0, 15)));
    endtask

    task automatic put_suffix(input logic [6:0] slot, input logic [3:0] pos,
                              input logic [7:0] c);
        send_byte(OP_SUFFIX_WR, c, slot, pos);
    endtask

    task automatic load_suffix(input logic [6:0] slot, input int len);
        for (int i = 0; i < len; i++) begin
            put_suffix(slot, 4'(i), 8'($urandom_range(1, 255)));
        end
        if (len < SUFFIX_LEN_DEF) begin
            put_suffix(slot, 4'(len), 8'd0);
        end
    endtask

    // wait for every owed character, then let any silent work finish
    task automatic settle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (chars_owed != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_registers(input bit e, input logic [6:0] code);
        ebcdic    = e;
        no_sfx    = code;
        cfg_we    <= 1'b1;
        cfg_index <= CFG_EBCDIC_MODE;
        cfg_data  <= CFG_DATA_W'(e);
        @(posedge aclk);
        cfg_index <= CFG_NO_SUFFIX_CODE;
        cfg_data  <= code;
        @(posedge aclk);
        cfg_index <= CFG_IDX_SPARE;
        cfg_data  <= CFG_DATA_W'($urandom_range(0, 127));
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    function automatic logic [7:0] plain_char();
        return ebcdic ? 8'($urandom_range(129, 255)) : 8'($urandom_range(0, 127));
    endfunction

    function automatic logic [7:0] end_byte();
        logic [6:0] code;
        case ($urandom_range(0, 5))
            0: begin
                code = no_sfx;
            end
            1: begin
                code = 7'($urandom_range(0, 127));
            end
            default: begin
                code = sfx_slot[$urandom_range(0, 3)];
            end
        endcase
        if (ebcdic && code == 7'd0 && $urandom_range(0, 1) == 1) return HIGH_BIT;
        return {~ebcdic, code};
    endfunction

    task automatic send_word();
        int         n_plain;
        logic [7:0] b;
        if ($urandom_range(0, 9) == 0) begin
            b = 8'($urandom_range(0, 255));
        end else begin
            b = LETTER_A + 8'($urandom_range(0, 12));
        end
        stream_byte(b);
        n_plain = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 36) : $urandom_range(0, 8);
        repeat (n_plain) stream_byte(plain_char());
        stream_byte(end_byte());
    endtask

    // receiver: stall pattern of its own, plus a long hold-off on request
    initial begin
        rx_mode_t mode;
        int       left;
        m_ready <= 1'b0;
        mode = RX_OPEN;
        left = 0;
        forever begin
            @(posedge aclk);
            if (hold_off_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
                hold_off_req = 1'b0;
            end else begin
                if (left == 0) begin
                    mode = rx_mode_t'($urandom_range(0, 3));
                    left = $urandom_range(20, 200);
                end
                left--;
                case (mode)
                    RX_OPEN: begin
                        m_ready <= 1'b1;
                    end
                    RX_COIN: begin
                        m_ready <= 1'($urandom_range(0, 1));
                    end
                    RX_BEAT: begin
                        m_ready <= (left % 4) != 0;
                    end
                    default: begin
                        m_ready <= ($urandom_range(0, 3) == 0);
                    end
                endcase
            end
        end
    end

    // watchdog on cycles without any transaction
    initial begin
        stuck_cycles = 0;
        while (stuck_cycles < STUCK_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                stuck_cycles = 0;
            end else begin
                stuck_cycles++;
            end
        end
        $display("Some tests failed");
        $finish;
    end

    initial begin
        bit         phase_ebcdic [PHASES];
        logic [6:0] phase_code [PHASES];
        phase_ebcdic = '{1'b0, 1'b1, 1'b0, 1'b1, 1'($urandom_range(0, 1))};
        phase_code   = '{NO_SUFFIX_RESET, 7'd0, 7'd0, NO_SUFFIX_RESET,
                         7'($urandom_range(0, 127))};
        aresetn         <= 1'b0;
        s_valid         <= 1'b0;
        s_opcode        <= OP_STREAM;
        s_data_byte     <= 8'd0;
        s_suffix_slot   <= 7'd0;
        s_char_position <= 4'd0;
        cfg_we          <= 1'b0;
        cfg_index       <= CFG_EBCDIC_MODE;
        cfg_data        <= '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        // clearing pass after reset
        do @(posedge aclk); while (!s_ready);

        for (int phase = 0; phase < PHASES; phase++) begin
            if (phase != 0) settle();
            set_registers(phase_ebcdic[phase], phase_code[phase]);
            tx_gappy = (phase != 1);
            if (phase == 0) begin
                put_suffix(7'd5, 4'd0, "i");
                put_suffix(7'd5, 4'd1, "n");
                put_suffix(7'd5, 4'd2, "g");
                put_suffix(7'd127, 4'd15, 8'hff);
                stream_byte(LETTER_A);
                stream_byte(8'h00);
                stream_byte(8'h7f);
                // empty suffix slot, bare end marker after plain characters
                stream_byte(HIGH_BIT);
                // count below the letter A
                stream_byte(8'h00);
                stream_byte({1'b1, NO_SUFFIX_RESET});
                // prefix reaching past the previous word
                stream_byte(LETTER_A + 8'd5);
                stream_byte(HIGH_BIT | 8'd5);
                // clamped count, then a suffix with no room left
                stream_byte(8'hff);
                stream_byte(HIGH_BIT | 8'd5);
                stream_byte(LETTER_A + 8'd30);
                stream_byte("x");
                stream_byte("y");
                stream_byte("z");
                stream_byte({1'b1, NO_SUFFIX_RESET});
            end
            for (int k = 0; k < 4; k++) begin
                sfx_slot[k] = 7'($urandom_range(0, 127));
                load_suffix(sfx_slot[k], $urandom_range(0, SUFFIX_LEN_DEF));
            end
            if (phase == 2) hold_off_req = 1'b1;
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                case ($urandom_range(0, 9))
                    0: begin
                        stream_byte(8'($urandom_range(0, 255)));
                    end
                    1: begin
                        put_suffix(7'($urandom_range(0, 127)), 4'($urandom_range(0, 15)),
                                   8'($urandom_range(0, 255)));
                    end
                    default: begin
                        send_word();
                    end
                endcase
            end
        end
        settle();
        if (mismatch_count == 0 && chars_owed == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

[filelist.f]
src/fcwd_pkg.sv
src/fcwd_ram.sv
src/fcwd_out_reg.sv
src/fcwd_seq.sv
src/front_coded_word_decoder_unit.sv
src/fcwd_checker.sv
dv/word_decode_checker.sv
dv/tb_front_coded_word_decoder_unit.sv
